// File: hdl/efsd_pkg.sv
// Shared types, widths and command codes for the earliest-free-server dispatcher.
package efsd_pkg;

  localparam int MAX_SERVERS = 16;
  localparam int TIME_BITS = 40;
  localparam int DUR_BITS = 24;
  localparam int CMD_BITS = 2;
  localparam int SRV_BITS = 4;
  localparam int MASK_BITS = 16;
  localparam int ACT_BITS = 5;
  localparam int IDX_BITS = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;

  localparam logic [ACT_BITS-1:0] ACT_RESET = ACT_BITS'(16);
  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};
  localparam logic [IDX_BITS-1:0] SEARCH_LAST = IDX_BITS'(MAX_SERVERS - 1);

  localparam logic [CMD_BITS-1:0] CMD_DISPATCH = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_QUERY = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_CLEAR = 2'd2;

  typedef logic [TIME_BITS-1:0] ftime_t;

  typedef struct packed {
    ftime_t ftime;
    logic [IDX_BITS-1:0] idx;
  } token_t;

  typedef struct packed {
    logic active;
    logic wr;
    logic clr;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_UPDATE
  } state_t;

endpackage

// File: hdl/efsd_cell.sv
// One server cell: holds a finish time and passes the running minimum to its neighbor.
module efsd_cell (
  input  logic                           clk,
  input  logic                           rst,
  input  efsd_pkg::cell_ctrl_t           ctrl,
  input  efsd_pkg::ftime_t               wr_time,
  input  efsd_pkg::ftime_t               cmp_time,
  input  logic [efsd_pkg::IDX_BITS-1:0]  own_idx,
  input  efsd_pkg::token_t               tok_in,
  output efsd_pkg::token_t               tok_out,
  output logic                           hit
);

  efsd_pkg::ftime_t ftime;

  always_ff @(posedge clk) begin
    if (rst) begin
      ftime <= '0;
    end else if (ctrl.clr) begin
      ftime <= '0;
    end else if (ctrl.wr) begin
      ftime <= wr_time;
    end
  end

  // A strict compare keeps the lower index on a tie.
  always_ff @(posedge clk) begin
    if (ctrl.active && (ftime < tok_in.ftime)) begin
      tok_out.ftime <= ftime;
      tok_out.idx <= own_idx;
    end else begin
      tok_out <= tok_in;
    end
  end

  assign hit = ctrl.active && (ftime == cmp_time);

endmodule

// File: hdl/earliest_free_server_dispatcher.sv
// Top level of the earliest-free-server dispatcher with its command sequencer.
// Each transaction on the job channel goes from acceptance to a result being offered
// through an accept step, a search in which the running minimum travels through the row
// of sixteen server cells (one cell per cycle, lowest index first so ties go to the
// lowest server), and an update step that updates the chosen cell or builds the free mask
// and loads the result register. One job is worked on at a time; a new job can be accepted
// as soon as the result register is loaded, even if that result has not yet been taken.
// The user must write active_servers via cfg_wr_en/cfg_wr_data only while no job is in
// progress; the block does not enforce it. Zero acts as one, above sixteen as sixteen.
module earliest_free_server_dispatcher (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [efsd_pkg::ACT_BITS-1:0]   cfg_wr_data,
  input  logic                            job_valid,
  output logic                            job_stall,
  input  logic [efsd_pkg::CMD_BITS-1:0]   cmd,
  input  logic [efsd_pkg::DUR_BITS-1:0]   duration,
  output logic                            res_valid,
  input  logic                            res_stall,
  output logic [efsd_pkg::SRV_BITS-1:0]   server,
  output logic [efsd_pkg::TIME_BITS-1:0]  event_time,
  output logic [efsd_pkg::MASK_BITS-1:0]  free_mask,
  output logic                            overflow
);

  efsd_pkg::state_t state;
  efsd_pkg::state_t state_next;
  logic [efsd_pkg::IDX_BITS-1:0] cnt;
  logic [efsd_pkg::ACT_BITS-1:0] active_servers;
  logic [efsd_pkg::CMD_BITS-1:0] cmd_q;
  logic [efsd_pkg::DUR_BITS-1:0] dur_q;
  logic saturated;

  efsd_pkg::token_t tok [0:efsd_pkg::MAX_SERVERS];
  efsd_pkg::cell_ctrl_t ctrl [0:efsd_pkg::MAX_SERVERS-1];
  logic [efsd_pkg::MAX_SERVERS-1:0] hits;

  efsd_pkg::token_t best;
  logic [efsd_pkg::TIME_BITS:0] sum;
  logic sum_ovf;
  efsd_pkg::ftime_t wr_time;
  logic accept;
  logic load;

  assign best = tok[efsd_pkg::MAX_SERVERS];
  assign tok[0].ftime = efsd_pkg::TIME_MAX;
  assign tok[0].idx = '0;

  assign sum = {1'b0, best.ftime} + (efsd_pkg::TIME_BITS + 1)'(dur_q);
  assign sum_ovf = sum[efsd_pkg::TIME_BITS];
  assign wr_time = sum_ovf ? efsd_pkg::TIME_MAX : sum[efsd_pkg::TIME_BITS-1:0];

  for (genvar i = 0; i < efsd_pkg::MAX_SERVERS; i++) begin : g_cell
    assign ctrl[i].active = (i == 0) ? 1'b1 : (32'(active_servers) > 32'(i));
    assign ctrl[i].wr = load && (cmd_q == efsd_pkg::CMD_DISPATCH) &&
                        (best.idx == efsd_pkg::IDX_BITS'(i));
    assign ctrl[i].clr = load && (cmd_q == efsd_pkg::CMD_CLEAR);

    efsd_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl[i]),
      .wr_time  (wr_time),
      .cmp_time (best.ftime),
      .own_idx  (efsd_pkg::IDX_BITS'(i)),
      .tok_in   (tok[i]),
      .tok_out  (tok[i+1]),
      .hit      (hits[i])
    );
  end

  always_comb begin
    state_next = state;
    case (state)
      efsd_pkg::S_IDLE: begin
        if (job_valid) begin
          state_next = efsd_pkg::S_SEARCH;
        end
      end
      efsd_pkg::S_SEARCH: begin
        if (cnt == efsd_pkg::SEARCH_LAST) begin
          state_next = efsd_pkg::S_UPDATE;
        end
      end
      efsd_pkg::S_UPDATE: begin
        if (!res_valid || !res_stall) begin
          state_next = efsd_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = efsd_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    job_stall = (state != efsd_pkg::S_IDLE);
    accept = job_valid && (state == efsd_pkg::S_IDLE);
    load = (state == efsd_pkg::S_UPDATE) && (!res_valid || !res_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= efsd_pkg::S_IDLE;
      cnt <= '0;
      active_servers <= efsd_pkg::ACT_RESET;
      saturated <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        cnt <= '0;
      end else if (state == efsd_pkg::S_SEARCH) begin
        cnt <= cnt + 1'b1;
      end
      if (cfg_wr_en) begin
        active_servers <= cfg_wr_data;
      end
      if (load) begin
        if (cmd_q == efsd_pkg::CMD_DISPATCH && sum_ovf) begin
          saturated <= 1'b1;
        end else if (cmd_q == efsd_pkg::CMD_CLEAR) begin
          saturated <= 1'b0;
        end
      end
      if (load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= cmd;
      dur_q <= duration;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      case (cmd_q)
        efsd_pkg::CMD_DISPATCH: begin
          server <= efsd_pkg::SRV_BITS'(best.idx);
          event_time <= best.ftime;
          free_mask <= '0;
          overflow <= saturated | sum_ovf;
        end
        efsd_pkg::CMD_QUERY: begin
          server <= '0;
          event_time <= best.ftime;
          free_mask <= efsd_pkg::MASK_BITS'(hits);
          overflow <= saturated;
        end
        efsd_pkg::CMD_CLEAR: begin
          server <= '0;
          event_time <= '0;
          free_mask <= '0;
          overflow <= 1'b0;
        end
        default: begin
          server <= '0;
          event_time <= '0;
          free_mask <= '0;
          overflow <= saturated;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_accept_starts_search: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == efsd_pkg::S_SEARCH) && (cnt == '0))
    else $error("Accepted transaction did not start a search.");

  a_search_full_length: assert property (@(posedge clk) disable iff (rst)
    (state == efsd_pkg::S_SEARCH) && (cnt != efsd_pkg::SEARCH_LAST)
      |=> (state == efsd_pkg::S_SEARCH))
    else $error("Search left the cell row before the minimum reached its end.");

  a_mask_only_on_query: assert property (@(posedge clk) disable iff (rst)
    res_valid && (free_mask != '0) |-> (server == '0))
    else $error("Free mask reported with a nonzero server.");

  a_sat_from_dispatch: assert property (@(posedge clk) disable iff (rst)
    $rose(saturated) |-> $past(load && (cmd_q == efsd_pkg::CMD_DISPATCH)))
    else $error("Saturation flag set outside a dispatch update.");
`endif

endmodule

// File: test/earliest_free_server_dispatcher_tb.sv
// Self-checking testbench: random and directed jobs checked against a cycle-free dispatch predictor.
module earliest_free_server_dispatcher_tb;

  localparam logic [efsd_pkg::CMD_BITS-1:0] CMD_UNKNOWN = 2'd3;
  localparam logic [efsd_pkg::DUR_BITS-1:0] DUR_MAX = {efsd_pkg::DUR_BITS{1'b1}};
  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [efsd_pkg::CMD_BITS-1:0] cmd;
    logic [efsd_pkg::DUR_BITS-1:0] duration;
  } job_item_t;

  typedef struct packed {
    logic [efsd_pkg::SRV_BITS-1:0]  server;
    efsd_pkg::ftime_t               event_time;
    logic [efsd_pkg::MASK_BITS-1:0] free_mask;
    logic                           overflow;
  } job_result_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_wr_en = 1'b0;
  logic [efsd_pkg::ACT_BITS-1:0]  cfg_wr_data = '0;
  logic                           job_valid = 1'b0;
  logic                           job_stall;
  logic [efsd_pkg::CMD_BITS-1:0]  cmd = '0;
  logic [efsd_pkg::DUR_BITS-1:0]  duration = '0;
  logic                           res_valid;
  logic                           res_stall = 1'b0;
  logic [efsd_pkg::SRV_BITS-1:0]  server;
  efsd_pkg::ftime_t               event_time;
  logic [efsd_pkg::MASK_BITS-1:0] free_mask;
  logic                           overflow;

  job_item_t   pending_jobs[$];
  job_result_t expected_results[$];

  efsd_pkg::ftime_t              server_finish[efsd_pkg::MAX_SERVERS];
  logic                          saturated_flag = 1'b0;
  logic [efsd_pkg::ACT_BITS-1:0] active_setting = efsd_pkg::ACT_RESET;

  int  mismatch_count = 0;
  int  results_checked = 0;
  int  idle_cycles = 0;
  int  burst_max = 8;
  int  gap_max = 0;
  int  burst_left = 0;
  int  gap_left = 0;
  int  stall_pct = 0;
  int  run_left = 0;
  int  hold_left = 0;
  int  holds_asked = 0;
  int  holds_served = 0;
  logic job_fire = 1'b0;

  earliest_free_server_dispatcher DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .job_valid   (job_valid),
    .job_stall   (job_stall),
    .cmd         (cmd),
    .duration    (duration),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .server      (server),
    .event_time  (event_time),
    .free_mask   (free_mask),
    .overflow    (overflow)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic job_result_t next_result(logic [efsd_pkg::CMD_BITS-1:0] c,
                                              logic [efsd_pkg::DUR_BITS-1:0] d);
    job_result_t                  r;
    int                           n;
    int                           best;
    efsd_pkg::ftime_t             start;
    logic [efsd_pkg::TIME_BITS:0] sum;
    n = active_setting;
    if (n < 1) n = 1;
    if (n > efsd_pkg::MAX_SERVERS) n = efsd_pkg::MAX_SERVERS;
    best = 0;
    for (int i = 1; i < n; i++) begin
      if (server_finish[i] < server_finish[best]) best = i;
    end
    r = '0;
    case (c)
      efsd_pkg::CMD_DISPATCH: begin
        start = server_finish[best];
        sum = {1'b0, start} +
              {{(efsd_pkg::TIME_BITS + 1 - efsd_pkg::DUR_BITS){1'b0}}, d};
        if (sum > {1'b0, efsd_pkg::TIME_MAX}) begin
          server_finish[best] = efsd_pkg::TIME_MAX;
          saturated_flag = 1'b1;
        end else begin
          server_finish[best] = sum[efsd_pkg::TIME_BITS-1:0];
        end
        r.server = efsd_pkg::SRV_BITS'(best);
        r.event_time = start;
      end
      efsd_pkg::CMD_QUERY: begin
        r.event_time = server_finish[best];
        for (int i = 0; i < n; i++) begin
          if (server_finish[i] == r.event_time) r.free_mask[i] = 1'b1;
        end
      end
      efsd_pkg::CMD_CLEAR: begin
        for (int i = 0; i < efsd_pkg::MAX_SERVERS; i++) server_finish[i] = '0;
        saturated_flag = 1'b0;
      end
      default: begin
      end
    endcase
    r.overflow = saturated_flag;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatch_count++;
    $display("MISMATCH %s: got %0h expected %0h at result %0d", what, got, want,
             results_checked);
  endtask

  always @(negedge clk) begin : drive_jobs
    job_item_t item;
    if (rst) begin
      job_valid <= 1'b0;
    end else if (!job_valid || job_fire) begin
      if (gap_left > 0) begin
        job_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_jobs.size() != 0) begin
        item = pending_jobs.pop_front();
        job_valid <= 1'b1;
        cmd <= item.cmd;
        duration <= item.duration;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, burst_max);
          gap_left <= (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        job_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else if (hold_left > 0) begin
      res_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_served != holds_asked) begin
      res_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      holds_served <= holds_served + 1;
    end else if (run_left > 0) begin
      run_left <= run_left - 1;
    end else begin
      res_stall <= ($urandom_range(0, 99) < stall_pct);
      run_left <= $urandom_range(0, 7);
    end
  end

  always @(posedge clk) begin : check_results
    job_result_t want;
    if (rst) begin
      job_fire <= 1'b0;
    end else begin
      job_fire <= job_valid && !job_stall;
      if (res_valid && !res_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with no transaction waiting", event_time, '0);
        end else begin
          want = expected_results.pop_front();
          if (server !== want.server) report_mismatch("server", server, want.server);
          if (event_time !== want.event_time)
            report_mismatch("event_time", event_time, want.event_time);
          if (free_mask !== want.free_mask)
            report_mismatch("free_mask", free_mask, want.free_mask);
          if (overflow !== want.overflow)
            report_mismatch("overflow", overflow, want.overflow);
        end
        results_checked++;
      end
      if (job_valid && !job_stall) expected_results.push_back(next_result(cmd, duration));
    end
  end

  always @(posedge clk) begin
    if (rst || (job_valid && !job_stall) || (res_valid && !res_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("** earliest_free_server_dispatcher: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic settle();
    @(posedge clk);
    #1;
  endtask

  task automatic wait_idle();
    do settle();
    while (pending_jobs.size() != 0 || expected_results.size() != 0 || job_valid);
    repeat (DRAIN_CYCLES) settle();
  endtask

  task automatic write_active(int value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= efsd_pkg::ACT_BITS'(value);
    active_setting = efsd_pkg::ACT_BITS'(value);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    settle();
  endtask

  task automatic push_job(logic [efsd_pkg::CMD_BITS-1:0] c,
                          logic [efsd_pkg::DUR_BITS-1:0] d);
    job_item_t item;
    item.cmd = c;
    item.duration = d;
    pending_jobs.push_back(item);
  endtask

  task automatic push_random_job();
    int                            sel;
    logic [efsd_pkg::CMD_BITS-1:0] c;
    logic [efsd_pkg::DUR_BITS-1:0] d;
    sel = $urandom_range(0, 99);
    if (sel < 68) c = efsd_pkg::CMD_DISPATCH;
    else if (sel < 88) c = efsd_pkg::CMD_QUERY;
    else if (sel < 94) c = efsd_pkg::CMD_CLEAR;
    else c = CMD_UNKNOWN;
    sel = $urandom_range(0, 99);
    if (sel < 40) d = $urandom_range(1, 16);
    else if (sel < 70) d = $urandom_range(1, 4095);
    else if (sel < 90) d = efsd_pkg::DUR_BITS'($urandom());
    else if (sel < 95) d = '0;
    else d = DUR_MAX;
    push_job(c, d);
  endtask

  task automatic set_pacing(int stall, int burst, int gap);
    stall_pct = stall;
    burst_max = burst;
    gap_max = gap;
  endtask

  initial begin
    for (int i = 0; i < efsd_pkg::MAX_SERVERS; i++) server_finish[i] = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    settle();

    set_pacing(0, 4, 3);
    push_job(efsd_pkg::CMD_QUERY, '0);
    push_job(efsd_pkg::CMD_DISPATCH, 24'd1);
    push_job(efsd_pkg::CMD_DISPATCH, DUR_MAX);
    push_job(efsd_pkg::CMD_DISPATCH, '0);
    push_job(efsd_pkg::CMD_QUERY, DUR_MAX);
    push_job(CMD_UNKNOWN, DUR_MAX);
    push_job(efsd_pkg::CMD_DISPATCH, 24'h555555);
    push_job(efsd_pkg::CMD_DISPATCH, 24'h555555);
    push_job(efsd_pkg::CMD_DISPATCH, 24'hAAAAAA);
    push_job(efsd_pkg::CMD_QUERY, '0);
    push_job(efsd_pkg::CMD_CLEAR, 24'h123456);
    push_job(efsd_pkg::CMD_QUERY, '0);
    wait_idle();

    write_active(1);
    push_job(efsd_pkg::CMD_DISPATCH, 24'd5);
    push_job(efsd_pkg::CMD_DISPATCH, '0);
    push_job(efsd_pkg::CMD_QUERY, '0);
    wait_idle();
    write_active(0);
    push_job(efsd_pkg::CMD_DISPATCH, 24'd7);
    push_job(efsd_pkg::CMD_QUERY, '0);
    wait_idle();
    write_active(31);
    push_job(efsd_pkg::CMD_QUERY, '0);
    push_job(efsd_pkg::CMD_DISPATCH, 24'd3);
    wait_idle();
    write_active(17);
    push_job(efsd_pkg::CMD_QUERY, '0);
    wait_idle();
    write_active(2);
    push_job(efsd_pkg::CMD_DISPATCH, 24'd9);
    push_job(efsd_pkg::CMD_DISPATCH, 24'd9);
    wait_idle();
    write_active(16);
    push_job(efsd_pkg::CMD_QUERY, '0);
    wait_idle();

    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0: write_active(16);
        1: write_active(1);
        2: write_active(0);
        3: write_active(31);
        default: write_active($urandom_range(0, 31));
      endcase
      set_pacing((phase % 3 == 0) ? 0 : $urandom_range(10, 70), $urandom_range(1, 12),
                 (phase % 4 == 1) ? 0 : $urandom_range(0, 30));
      if ($urandom_range(0, 1) != 0) push_job(efsd_pkg::CMD_CLEAR, '0);
      repeat (70) push_random_job();
      if (phase == 5) holds_asked++;
      wait_idle();
    end

    if (expected_results.size() != 0)
      report_mismatch("results never returned", expected_results.size(), '0);
    if (mismatch_count == 0) begin
      $display("** earliest_free_server_dispatcher: PASSED **");
    end else begin
      $display("** earliest_free_server_dispatcher: FAILED **");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/efsd_pkg.sv
hdl/efsd_cell.sv
hdl/earliest_free_server_dispatcher.sv
test/earliest_free_server_dispatcher_tb.sv
